[sv/iban_stream_validator_assert.svh]
// Assertion macros for the IBAN validator checker.
`ifndef IBAN_STREAM_VALIDATOR_ASSERT_SVH
`define IBAN_STREAM_VALIDATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define IBSV_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ibsv: same-cycle property failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define IBSV_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ibsv: next-cycle property failed");

`endif

[sv/ibsv_pkg.sv]
// Shared types, constants and mod 97 arithmetic for the IBAN validator.
`default_nettype none

package ibsv_pkg;

	localparam int MAX_BLOCKS_DEF = 6;
	// Block fields are looked up as if the registers had this many slots.
	localparam int BLK_SLOTS = 8;
	localparam int LEN_W = 5;
	localparam int KIND_W = 2;
	localparam int LENS_REG_W = 30;
	localparam int KINDS_REG_W = 12;

	localparam logic [5:0] POS_MAX = 6'd63;
	localparam logic [5:0] HEAD_LEN = 6'd4;
	localparam logic [5:0] MIN_LEN = 6'd2;

	localparam int MODULUS = 97;
	localparam logic [7:0] LETTER_BIAS = 8'd55;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	// 128 mod 97, used to fold the upper bits of a wide value.
	localparam int BASE_FOLD = 31;
	// floor(x / 97) == (x * RECIP) >> RECIP_SH, exact for x < 2048.
	localparam int RECIP = 2703;
	localparam int RECIP_SH = 18;

	typedef enum logic [2:0] {
		REG_COUNTRY   = 3'd0,
		REG_IBAN_LEN  = 3'd1,
		REG_BLK_COUNT = 3'd2,
		REG_BLK_KINDS = 3'd3,
		REG_BLK_LENS  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_DIGIT = 2'd0,
		KIND_ALNUM = 2'd1,
		KIND_ALPHA = 2'd2,
		KIND_NONE  = 2'd3
	} blk_kind_t;

	typedef struct packed {
		logic [15:0]            country;
		logic [5:0]             iban_len;
		logic [2:0]             blk_count;
		logic [KINDS_REG_W-1:0] blk_kinds;
		logic [LENS_REG_W-1:0]  blk_lens;
	} cfg_t;

	// State of one finished IBAN, handed from the character stage to the result pipe.
	typedef struct packed {
		logic [6:0] rem;
		logic [6:0] mult;
		logic [6:0] add;
		logic [4:0] fill;
		logic       len_ok;
		logic       chk_ok;
	} summary_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		if ((c >= 8'h61) && (c <= 8'h7A))
			return c - CASE_OFFSET;
		return c;
	endfunction

	function automatic logic [6:0] mod97(input logic [10:0] x);
		logic [22:0] prod;
		logic [10:0] qm;
		prod = {12'd0, x} * 23'(RECIP);
		qm = 11'(prod[22:RECIP_SH]) * 11'(MODULUS);
		return 7'(x - qm);
	endfunction

	function automatic logic [6:0] mod97_wide(input logic [13:0] x);
		logic [11:0] y1;
		logic [10:0] y2;
		y1 = 12'(x[13:7]) * 12'(BASE_FOLD) + 12'(x[6:0]);
		y2 = 11'(y1[11:7]) * 11'(BASE_FOLD) + 11'(y1[6:0]);
		return mod97(y2);
	endfunction

	// Multiply by the decimal weight of c mod 97: 10 for a digit, 100 = 3 for a letter.
	function automatic logic [9:0] char_scale(input logic [6:0] x, input logic [7:0] c);
		logic [9:0] xe;
		xe = {3'b000, x};
		if (is_digit(c))
			return (xe << 3) + (xe << 1);
		if (is_letter(c))
			return (xe << 1) + xe;
		return xe;
	endfunction

	function automatic logic [9:0] char_value(input logic [7:0] c);
		if (is_digit(c))
			return {2'b00, c - 8'h30};
		if (is_letter(c))
			return {2'b00, c - LETTER_BIAS};
		return 10'd0;
	endfunction

	function automatic logic [6:0] fold_char(input logic [6:0] r, input logic [7:0] c);
		return mod97({1'b0, char_scale(r, c) + char_value(c)});
	endfunction

	function automatic logic [6:0] scale_char(input logic [6:0] x, input logic [7:0] c);
		return mod97({1'b0, char_scale(x, c)});
	endfunction

endpackage

`default_nettype wire

[sv/iban_stream_validator.sv]
// Top level of the streaming IBAN validator.
//
// Usage:
//   Characters enter on the input channel (in_valid/in_stall, char_code,
//   last_char), one per cycle while in_stall is low; lower-case letters are
//   folded to upper case. last_char marks the final character of an IBAN.
//   One result (iban_valid) leaves on the output channel (out_valid/out_stall)
//   for each IBAN, once its summary has passed the result pipe. Throughput
//   is one character per cycle unless stalled; the remainder update and block
//   match are one step of logic per character, and the end-of-IBAN work runs
//   in a three-register pipe so the next IBAN can follow right away.
//   The country spec is written through cfg_we/cfg_index/cfg_data while idle.
//   Reset clears the per-IBAN state and loads the register defaults
//   (block count one, everything else zero).
//   When the receiver stalls, the result holds; up to two more finished
//   IBANs queue behind it, after which in_stall rises until the output drains.
`default_nettype none

module iban_stream_validator #(
	parameter int MAX_BLOCKS = ibsv_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        iban_valid,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [29:0] cfg_data
);
	import ibsv_pkg::*;

	localparam int BIDX_W = $clog2(MAX_BLOCKS + 1);

	cfg_t              cfg_q;
	summary_t          sum;
	logic [BIDX_W-1:0] bidx_nx;
	logic              ready;
	logic              accept;

	assign in_stall = !ready;
	assign accept = in_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.country <= '0;
			cfg_q.iban_len <= '0;
			cfg_q.blk_count <= 3'd1;
			cfg_q.blk_kinds <= '0;
			cfg_q.blk_lens <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COUNTRY:   cfg_q.country <= cfg_data[15:0];
				REG_IBAN_LEN:  cfg_q.iban_len <= cfg_data[5:0];
				REG_BLK_COUNT: cfg_q.blk_count <= cfg_data[2:0];
				REG_BLK_KINDS: cfg_q.blk_kinds <= cfg_data[KINDS_REG_W-1:0];
				REG_BLK_LENS:  cfg_q.blk_lens <= cfg_data[LENS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	ibsv_char_stage #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.BIDX_W     (BIDX_W)
	) u_char (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.last_char (last_char),
		.cfg       (cfg_q),
		.sum       (sum),
		.bidx_nx   (bidx_nx)
	);

	ibsv_result_pipe #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.BIDX_W     (BIDX_W)
	) u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && last_char),
		.sum        (sum),
		.bidx       (bidx_nx),
		.cfg        (cfg_q),
		.out_stall  (out_stall),
		.ready      (ready),
		.out_valid  (out_valid),
		.iban_valid (iban_valid)
	);

endmodule

`default_nettype wire

[sv/ibsv_blk_search.sv]
// Finds the first non-empty structure block at or after a start index.
`default_nettype none

module ibsv_blk_search #(
	parameter int MAX_BLOCKS = ibsv_pkg::MAX_BLOCKS_DEF,
	parameter int BIDX_W = $clog2(MAX_BLOCKS + 1)
) (
	input  ibsv_pkg::cfg_t         cfg,
	input  logic [BIDX_W-1:0]      start,
	output logic                   hit,
	output logic [BIDX_W-1:0]      idx,
	output ibsv_pkg::blk_kind_t    kind,
	output logic [ibsv_pkg::LEN_W-1:0] len
);
	import ibsv_pkg::*;

	localparam int LENS_EXT_W = BLK_SLOTS * LEN_W;
	localparam int KINDS_EXT_W = BLK_SLOTS * KIND_W;

	logic [BIDX_W-1:0]      used;
	logic [LENS_EXT_W-1:0]  lens_ext;
	logic [KINDS_EXT_W-1:0] kinds_ext;

	assign lens_ext = {{(LENS_EXT_W - LENS_REG_W){1'b0}}, cfg.blk_lens};
	assign kinds_ext = {{(KINDS_EXT_W - KINDS_REG_W){1'b0}}, cfg.blk_kinds};

	always_comb begin
		if (int'(cfg.blk_count) > MAX_BLOCKS)
			used = BIDX_W'(MAX_BLOCKS);
		else
			used = BIDX_W'(cfg.blk_count);
	end

	always_comb begin
		hit = 1'b0;
		// With nothing left, idx is the larger of start and the block count.
		idx = (start >= used) ? start : used;
		kind = KIND_NONE;
		len = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			if (!hit && (i >= int'(start)) && (i < int'(used))
					&& (lens_ext[i*LEN_W +: LEN_W] != '0)) begin
				hit = 1'b1;
				idx = BIDX_W'(i);
				kind = blk_kind_t'(kinds_ext[i*KIND_W +: KIND_W]);
				len = lens_ext[i*LEN_W +: LEN_W];
			end
		end
	end

endmodule

`default_nettype wire

[sv/ibsv_char_stage.sv]
// Per-character state: position, head fold factors, remainder and structure tracking.
`default_nettype none

module ibsv_char_stage #(
	parameter int MAX_BLOCKS = ibsv_pkg::MAX_BLOCKS_DEF,
	parameter int BIDX_W = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_code,
	input  logic                last_char,
	input  ibsv_pkg::cfg_t      cfg,
	output ibsv_pkg::summary_t  sum,
	output logic [BIDX_W-1:0]   bidx_nx
);
	import ibsv_pkg::*;

	logic [5:0]        pos_q;
	logic [6:0]        rem_q;
	logic [6:0]        mult_q;
	logic [6:0]        add_q;
	logic [BIDX_W-1:0] bidx_q;
	logic [4:0]        fill_q;
	logic              ok_q;

	logic [5:0]        pos_nx;
	logic [6:0]        rem_nx;
	logic [6:0]        mult_nx;
	logic [6:0]        add_nx;
	logic [4:0]        fill_nx;
	logic              ok_nx;

	logic [7:0]        c_up;
	logic              blk_hit;
	logic [BIDX_W-1:0] blk_idx;
	blk_kind_t         blk_kind;
	logic [LEN_W-1:0]  blk_len;
	logic              fits;
	logic [5:0]        fill_inc;

	ibsv_blk_search #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.BIDX_W     (BIDX_W)
	) u_search (
		.cfg   (cfg),
		.start (bidx_q),
		.hit   (blk_hit),
		.idx   (blk_idx),
		.kind  (blk_kind),
		.len   (blk_len)
	);

	assign c_up = to_upper(char_code);
	assign fill_inc = {1'b0, fill_q} + 6'd1;

	always_comb begin
		case (blk_kind)
			KIND_DIGIT: fits = is_digit(c_up);
			KIND_ALNUM: fits = is_digit(c_up) || is_letter(c_up);
			KIND_ALPHA: fits = is_letter(c_up);
			KIND_NONE:  fits = 1'b0;
			default:    fits = 1'b0;
		endcase
	end

	always_comb begin
		pos_nx = (pos_q == POS_MAX) ? POS_MAX : pos_q + 6'd1;
		rem_nx = rem_q;
		mult_nx = mult_q;
		add_nx = add_q;
		bidx_nx = bidx_q;
		fill_nx = fill_q;
		ok_nx = ok_q;
		if (pos_q < HEAD_LEN) begin
			// Head characters build an affine fold applied after the body remainder.
			mult_nx = scale_char(mult_q, c_up);
			add_nx = fold_char(add_q, c_up);
			if ((pos_q == 6'd0) && (c_up != cfg.country[15:8]))
				ok_nx = 1'b0;
			if ((pos_q == 6'd1) && (c_up != cfg.country[7:0]))
				ok_nx = 1'b0;
		end else begin
			rem_nx = fold_char(rem_q, c_up);
			bidx_nx = blk_idx;
			if (!blk_hit || !fits)
				ok_nx = 1'b0;
			if (blk_hit) begin
				if (fill_inc >= {1'b0, blk_len}) begin
					bidx_nx = BIDX_W'(blk_idx + 1'b1);
					fill_nx = '0;
				end else begin
					fill_nx = fill_inc[4:0];
				end
			end
		end
	end

	always_comb begin
		sum.rem = rem_nx;
		sum.mult = mult_nx;
		sum.add = add_nx;
		sum.fill = fill_nx;
		sum.len_ok = (pos_nx == cfg.iban_len);
		sum.chk_ok = ok_nx && (pos_nx >= MIN_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rem_q <= '0;
			mult_q <= 7'd1;
			add_q <= '0;
			bidx_q <= '0;
			fill_q <= '0;
			ok_q <= 1'b1;
		end else if (accept) begin
			if (last_char) begin
				// Start the next IBAN from a clean state.
				pos_q <= '0;
				rem_q <= '0;
				mult_q <= 7'd1;
				add_q <= '0;
				bidx_q <= '0;
				fill_q <= '0;
				ok_q <= 1'b1;
			end else begin
				pos_q <= pos_nx;
				rem_q <= rem_nx;
				mult_q <= mult_nx;
				add_q <= add_nx;
				bidx_q <= bidx_nx;
				fill_q <= fill_nx;
				ok_q <= ok_nx;
			end
		end
	end

endmodule

`default_nettype wire

[sv/ibsv_result_pipe.sv]
// End-of-IBAN pipe: structure close-out, check-digit product, final mod 97 and output register.
`default_nettype none

module ibsv_result_pipe #(
	parameter int MAX_BLOCKS = ibsv_pkg::MAX_BLOCKS_DEF,
	parameter int BIDX_W = $clog2(MAX_BLOCKS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ibsv_pkg::summary_t sum,
	input  logic [BIDX_W-1:0]  bidx,
	input  ibsv_pkg::cfg_t     cfg,
	input  logic               out_stall,
	output logic               ready,
	output logic               out_valid,
	output logic               iban_valid
);
	import ibsv_pkg::*;

	logic              v_s1;
	summary_t          sum_s1;
	logic [BIDX_W-1:0] bidx_s1;
	logic              v_s2;
	logic [13:0]       prod_s2;
	logic              ok_s2;
	logic              out_valid_q;
	logic              iban_valid_q;

	logic              ready_out;
	logic              ready_s2;
	logic              tail_hit;
	logic [BIDX_W-1:0] tail_idx;
	blk_kind_t         tail_kind;
	logic [LEN_W-1:0]  tail_len;
	logic              unused_tail;

	ibsv_blk_search #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.BIDX_W     (BIDX_W)
	) u_tail (
		.cfg   (cfg),
		.start (bidx_s1),
		.hit   (tail_hit),
		.idx   (tail_idx),
		.kind  (tail_kind),
		.len   (tail_len)
	);

	// Only the hit flag matters at the end of an IBAN.
	assign unused_tail = ^{tail_idx, tail_kind, tail_len};

	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2 = !v_s2 || ready_out;
	assign ready = !v_s1 || ready_s2;
	assign out_valid = out_valid_q;
	assign iban_valid = iban_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push)
				v_s1 <= 1'b1;
			else if (ready_s2)
				v_s1 <= 1'b0;
			if (ready_s2)
				v_s2 <= v_s1;
			if (ready_out)
				out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sum_s1 <= sum;
			bidx_s1 <= bidx;
		end
		if (ready_s2 && v_s1) begin
			prod_s2 <= 14'(sum_s1.mult) * 14'(sum_s1.rem) + 14'(sum_s1.add);
			// Fail on a wrong length, a failed character check, a block left open or blocks still owed.
			ok_s2 <= sum_s1.len_ok && sum_s1.chk_ok && !tail_hit
				&& (sum_s1.fill == '0) && !(unused_tail && 1'b0);
		end
		if (ready_out && v_s2)
			iban_valid_q <= ok_s2 && (mod97_wide(prod_s2) == 7'd1);
	end

endmodule

`default_nettype wire

[sv/ibsv_checker.sv]
// Port-level checks for the IBAN validator, bound to the top level.
`default_nettype none

`include "iban_stream_validator_assert.svh"

module ibsv_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic iban_valid
);

	// A stalled result stays up and unchanged.
	`IBSV_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(iban_valid))

	// Input backs up only when the output side is blocked.
	`IBSV_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

	// No result right after reset lets go.
	`IBSV_ASSERT_IMP(a_quiet_after_reset, $past(!arst_n), !out_valid)

endmodule

bind iban_stream_validator ibsv_checker u_ibsv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.iban_valid (iban_valid)
);

`default_nettype wire
